// ===== rtl/core/stcp_pkg.sv =====
// ----------------------------------------------------------------------------
// stcp_pkg
// Shared types and constants for the sphere / triangle closest point block.
// ----------------------------------------------------------------------------
package stcp_pkg;

  localparam int RADIUS_W   = 31;
  localparam int DIST_W     = 63;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 31'd65536;

  // word index of the configuration registers
  localparam logic [0:0] REG_SPHERE_RADIUS = 1'b0;

  typedef enum logic [2:0] {
    RGN_VERT0  = 3'd0,
    RGN_VERT1  = 3'd1,
    RGN_VERT2  = 3'd2,
    RGN_EDGE01 = 3'd3,
    RGN_EDGE02 = 3'd4,
    RGN_EDGE12 = 3'd5,
    RGN_FACE   = 3'd6
  } region_t;

  typedef struct packed {
    region_t region;
    logic    use_div;
    logic    degen;
  } ctl_t;

endpackage

// ===== rtl/core/stcp_if.sv =====
// ----------------------------------------------------------------------------
// stcp_if
// Valid/ready channels: query (point and triangle) and result.
// ----------------------------------------------------------------------------
interface stcp_query_if #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] point_x;
  logic signed [W-1:0] point_y;
  logic signed [W-1:0] point_z;
  logic signed [W-1:0] vert0_x;
  logic signed [W-1:0] vert0_y;
  logic signed [W-1:0] vert0_z;
  logic signed [W-1:0] vert1_x;
  logic signed [W-1:0] vert1_y;
  logic signed [W-1:0] vert1_z;
  logic signed [W-1:0] vert2_x;
  logic signed [W-1:0] vert2_y;
  logic signed [W-1:0] vert2_z;

  modport source (
    output valid, point_x, point_y, point_z, vert0_x, vert0_y, vert0_z,
           vert1_x, vert1_y, vert1_z, vert2_x, vert2_y, vert2_z,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, vert0_x, vert0_y, vert0_z,
           vert1_x, vert1_y, vert1_z, vert2_x, vert2_y, vert2_z,
    output ready
  );
endinterface

interface stcp_result_if import stcp_pkg::*; #(parameter int W = 32);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] closest_x;
  logic signed [W-1:0] closest_y;
  logic signed [W-1:0] closest_z;
  region_t             region;
  logic [DIST_W-1:0]   distance_sq;
  logic                hit;
  logic                degenerate;

  modport source (
    output valid, closest_x, closest_y, closest_z, region, distance_sq, hit,
           degenerate,
    input  ready
  );
  modport sink (
    input  valid, closest_x, closest_y, closest_z, region, distance_sq, hit,
           degenerate,
    output ready
  );
endinterface

// ===== rtl/core/sphere_triangle_closest_point.sv =====
// ----------------------------------------------------------------------------
// sphere_triangle_closest_point
// Closest point on a triangle to a query point, region code, squared
// distance and sphere hit flag.
//
//   channel   dir   handshake        payload
//   query     in    valid / ready    point, vert0, vert1, vert2 (x, y, z)
//   result    out   valid / ready    closest xyz, region, distance_sq, hit,
//                                    degenerate
//   apb       in    psel / penable   sphere_radius at word 0
//
// One item per cycle unless the result stalls; pipeline depth is set mostly
// by the one-bit-per-stage divider for the edge and face points.
// Reset clears the valid bits and loads the radius register.
// A stall at the result freezes the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module sphere_triangle_closest_point import stcp_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  stcp_query_if.sink            query,
  stcp_result_if.source         result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int W    = COORD_WIDTH;
  localparam int EW   = W + 1;
  localparam int DDW  = 2 * EW + 2;
  localparam int VW   = 2 * DDW + 1;
  localparam int DNW  = VW + 2;
  localparam int NUMW = EW + VW + 1;
  localparam int QW   = W + 2;
  localparam int SQ   = 11 + QW + 2;
  localparam int L    = SQ + 6;
  localparam int CW   = $bits(ctl_t);
  localparam int XW   = (DDW > 64) ? DDW : 64;

  localparam logic signed [QW+1:0] CMAX = (QW+2)'((64'sd1 <<< (W - 1)) - 64'sd1);
  localparam logic signed [QW+1:0] CMIN = -CMAX - 1;

  localparam int XA [6] = '{0, 2, 4, 0, 2, 4};
  localparam int XB [6] = '{3, 1, 1, 5, 5, 3};

  // ---------------- configuration ----------------
  logic [RADIUS_W-1:0]   radius;
  logic [2*RADIUS_W-1:0] rr;
  logic [0:0]            widx;

  assign widx   = paddr[CFG_ADDR_W-1:2];
  assign pready = 1'b1;
  assign prdata = (widx == REG_SPHERE_RADIUS) ? CFG_DATA_W'(radius) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (psel && penable && pwrite && pready && widx == REG_SPHERE_RADIUS) begin
      radius <= pwdata[RADIUS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rr <= (2*RADIUS_W)'(radius) * (2*RADIUS_W)'(radius);
  end

  // ---------------- flow control ----------------
  logic         en;
  logic [L:1]   vld;

  assign en          = !vld[L] || result.ready;
  assign query.ready = en;
  assign result.valid = vld[L];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[L-1:1], query.valid};
    end
  end

  // ---------------- input ----------------
  logic signed [W-1:0] pin [3];
  logic signed [W-1:0] vin [3][3];
  logic [9*W-1:0]      v_pk;
  logic [3*W-1:0]      p_pk;

  assign pin[0]    = query.point_x;
  assign pin[1]    = query.point_y;
  assign pin[2]    = query.point_z;
  assign vin[0][0] = query.vert0_x;
  assign vin[0][1] = query.vert0_y;
  assign vin[0][2] = query.vert0_z;
  assign vin[1][0] = query.vert1_x;
  assign vin[1][1] = query.vert1_y;
  assign vin[1][2] = query.vert1_z;
  assign vin[2][0] = query.vert2_x;
  assign vin[2][1] = query.vert2_y;
  assign vin[2][2] = query.vert2_z;

  for (genvar j = 0; j < 3; j++) begin : g_vpk
    for (genvar i = 0; i < 3; i++) begin : g_ax
      assign v_pk[(j*3+i)*W +: W] = vin[j][i];
    end
    assign p_pk[j*W +: W] = pin[j];
  end

  // ---------------- S1: edges and offsets ----------------
  logic signed [EW-1:0] ev [3][3];
  logic signed [EW-1:0] qv [3][3];
  logic [9*EW-1:0]      e_pk;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ev[0][i] <= EW'(vin[1][i]) - EW'(vin[0][i]);
        ev[1][i] <= EW'(vin[2][i]) - EW'(vin[0][i]);
        ev[2][i] <= EW'(vin[2][i]) - EW'(vin[1][i]);
        for (int j = 0; j < 3; j++) begin
          qv[j][i] <= EW'(pin[i]) - EW'(vin[j][i]);
        end
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_epk
    for (genvar i = 0; i < 3; i++) begin : g_ax
      assign e_pk[(j*3+i)*EW +: EW] = ev[j][i];
    end
  end

  // ---------------- S2..S4: d1..d6 ----------------
  logic signed [2*EW-1:0] dp [6][3];
  logic signed [DDW-1:0]  d4s [6];
  logic [6*DDW-1:0]       d_pk;

  for (genvar k = 0; k < 6; k++) begin : g_dot
    for (genvar i = 0; i < 3; i++) begin : g_ax
      stcp_mul #(.AW(EW), .BW(EW)) u_mul (
        .clk (clk),
        .en  (en),
        .a   (ev[k%2][i]),
        .b   (qv[k/2][i]),
        .p   (dp[k][i])
      );
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d4s[k] <= DDW'(dp[k][0]) + DDW'(dp[k][1]) + DDW'(dp[k][2]);
      end
    end
    assign d_pk[k*DDW +: DDW] = d4s[k];
  end

  // ---------------- S5..S7: va, vb, vc ----------------
  logic signed [2*DDW-1:0] xp [6];
  logic signed [VW-1:0]    va7, vb7, vc7;

  for (genvar k = 0; k < 6; k++) begin : g_cross
    stcp_mul #(.AW(DDW), .BW(DDW)) u_mul (
      .clk (clk),
      .en  (en),
      .a   (d4s[XA[k]]),
      .b   (d4s[XB[k]]),
      .p   (xp[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vc7 <= VW'(xp[0]) - VW'(xp[1]);
      vb7 <= VW'(xp[2]) - VW'(xp[3]);
      va7 <= VW'(xp[4]) - VW'(xp[5]);
    end
  end

  // side data aligned to S7
  logic [6*DDW-1:0]     d7_pk;
  logic [9*EW-1:0]      e7_pk;
  logic [9*W-1:0]       v7_pk;
  logic signed [DDW-1:0] d7 [6];
  logic signed [EW-1:0]  e7 [3][3];
  logic signed [W-1:0]   v7 [3][3];

  stcp_pipe #(.W(6*DDW), .DEPTH(3)) u_d7 (.clk(clk), .en(en), .d(d_pk), .q(d7_pk));
  stcp_pipe #(.W(9*EW),  .DEPTH(6)) u_e7 (.clk(clk), .en(en), .d(e_pk), .q(e7_pk));
  stcp_pipe #(.W(9*W),   .DEPTH(7)) u_v7 (.clk(clk), .en(en), .d(v_pk), .q(v7_pk));

  for (genvar k = 0; k < 6; k++) begin : g_d7
    assign d7[k] = $signed(d7_pk[k*DDW +: DDW]);
  end
  for (genvar j = 0; j < 3; j++) begin : g_ev7
    for (genvar i = 0; i < 3; i++) begin : g_ax
      assign e7[j][i] = $signed(e7_pk[(j*3+i)*EW +: EW]);
      assign v7[j][i] = $signed(v7_pk[(j*3+i)*W +: W]);
    end
  end

  // ---------------- S8: region decision ----------------
  logic signed [DDW:0]   tn43, tn56;
  logic                  c0, c1, c2, c3, c4, c5;
  region_t               rg;
  logic                  is_edge, is_face;
  logic signed [W-1:0]   base_s [3];
  logic signed [EW-1:0]  dir_s [3];
  logic signed [VW-1:0]  tnum;
  logic signed [DNW-1:0] tden, fden, den_s;
  ctl_t                  ctl_s;

  assign tn43 = (DDW+1)'(d7[3]) - (DDW+1)'(d7[2]);
  assign tn56 = (DDW+1)'(d7[4]) - (DDW+1)'(d7[5]);
  assign fden = DNW'(va7) + DNW'(vb7) + DNW'(vc7);

  assign c0 = d7[0] <= 0 && d7[1] <= 0;
  assign c1 = d7[2] >= 0 && d7[3] <= d7[2];
  assign c3 = vc7 <= 0 && d7[0] >= 0 && d7[2] <= 0;
  assign c2 = d7[5] >= 0 && d7[4] <= d7[5];
  assign c4 = vb7 <= 0 && d7[1] >= 0 && d7[5] <= 0;
  assign c5 = va7 <= 0 && tn43 >= 0 && tn56 >= 0;

  always_comb begin
    rg      = RGN_FACE;
    is_edge = 1'b0;
    is_face = 1'b0;
    tnum    = '0;
    tden    = '0;
    for (int i = 0; i < 3; i++) begin
      base_s[i] = v7[0][i];
      dir_s[i]  = e7[0][i];
    end
    if (c0) begin
      rg = RGN_VERT0;
    end else if (c1) begin
      rg = RGN_VERT1;
      for (int i = 0; i < 3; i++) base_s[i] = v7[1][i];
    end else if (c3) begin
      rg      = RGN_EDGE01;
      is_edge = 1'b1;
      tnum    = VW'(d7[0]);
      tden    = DNW'(d7[0]) - DNW'(d7[2]);
    end else if (c2) begin
      rg = RGN_VERT2;
      for (int i = 0; i < 3; i++) base_s[i] = v7[2][i];
    end else if (c4) begin
      rg      = RGN_EDGE02;
      is_edge = 1'b1;
      tnum    = VW'(d7[1]);
      tden    = DNW'(d7[1]) - DNW'(d7[5]);
      for (int i = 0; i < 3; i++) dir_s[i] = e7[1][i];
    end else if (c5) begin
      rg      = RGN_EDGE12;
      is_edge = 1'b1;
      tnum    = VW'(tn43);
      tden    = DNW'(tn43) + DNW'(tn56);
      for (int i = 0; i < 3; i++) begin
        base_s[i] = v7[1][i];
        dir_s[i]  = e7[2][i];
      end
    end else begin
      is_face = 1'b1;
    end
    den_s         = is_face ? fden : tden;
    ctl_s.region  = rg;
    ctl_s.use_div = (is_edge || is_face) && den_s != 0;
    ctl_s.degen   = is_face && den_s == 0;
  end

  ctl_t                  ctl8;
  logic signed [W-1:0]   base8 [3];
  logic signed [EW-1:0]  a1_8 [3];
  logic signed [EW-1:0]  a2_8 [3];
  logic signed [VW-1:0]  b1_8, b2_8;
  logic signed [DNW-1:0] den8;
  logic [CW+3*W-1:0]     s8_pk;

  always_ff @(posedge clk) begin
    if (en) begin
      ctl8 <= ctl_s;
      den8 <= den_s;
      b1_8 <= is_face ? vb7 : tnum;
      b2_8 <= is_face ? vc7 : '0;
      for (int i = 0; i < 3; i++) begin
        base8[i] <= base_s[i];
        a1_8[i]  <= is_face ? e7[0][i] : dir_s[i];
        a2_8[i]  <= e7[1][i];
      end
    end
  end

  assign s8_pk = {ctl8, base8[2], base8[1], base8[0]};

  // ---------------- S9..S11: numerators ----------------
  logic signed [EW+VW-1:0] m1 [3];
  logic signed [EW+VW-1:0] m2 [3];
  logic signed [NUMW-1:0]  num11 [3];
  logic [DNW-1:0]          den11;
  logic signed [QW:0]      quo [3];

  stcp_pipe #(.W(DNW), .DEPTH(3)) u_den (.clk(clk), .en(en), .d(den8), .q(den11));

  for (genvar i = 0; i < 3; i++) begin : g_num
    stcp_mul #(.AW(EW), .BW(VW)) u_mul1 (
      .clk (clk), .en (en), .a (a1_8[i]), .b (b1_8), .p (m1[i])
    );
    stcp_mul #(.AW(EW), .BW(VW)) u_mul2 (
      .clk (clk), .en (en), .a (a2_8[i]), .b (b2_8), .p (m2[i])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        num11[i] <= NUMW'(m1[i]) + NUMW'(m2[i]);
      end
    end
    stcp_div #(.NW(NUMW), .DW(DNW), .QW(QW)) u_div (
      .clk (clk),
      .en  (en),
      .num (num11[i]),
      .den ($signed(den11)),
      .quo (quo[i])
    );
  end

  // ---------------- SQ+1: closest point ----------------
  logic [CW+3*W-1:0]   sq_pk;
  ctl_t                ctl_q;
  logic signed [W-1:0] base_q [3];
  logic signed [W-1:0] cpt [3];
  ctl_t                ctl_c;
  logic [3*W-1:0]      c_pk;

  stcp_pipe #(.W(CW+3*W), .DEPTH(SQ-8)) u_side (
    .clk (clk), .en (en), .d (s8_pk), .q (sq_pk)
  );

  assign ctl_q = ctl_t'(sq_pk[CW+3*W-1:3*W]);

  for (genvar i = 0; i < 3; i++) begin : g_cpt
    logic signed [QW+1:0] sum;

    assign base_q[i] = $signed(sq_pk[i*W +: W]);
    assign sum       = (QW+2)'(base_q[i]) + (QW+2)'(quo[i]);

    always_ff @(posedge clk) begin
      if (en) begin
        if (!ctl_q.use_div) begin
          cpt[i] <= base_q[i];
        end else if (sum > CMAX) begin
          cpt[i] <= CMAX[W-1:0];
        end else if (sum < CMIN) begin
          cpt[i] <= CMIN[W-1:0];
        end else begin
          cpt[i] <= sum[W-1:0];
        end
      end
    end
    assign c_pk[i*W +: W] = cpt[i];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_c <= ctl_q;
    end
  end

  // ---------------- SQ+2..SQ+5: squared distance ----------------
  logic [3*W-1:0]         pq_pk;
  logic signed [EW-1:0]   dq [3];
  logic signed [2*EW-1:0] sqp [3];
  logic signed [DDW-1:0]  dsum;

  stcp_pipe #(.W(3*W), .DEPTH(SQ+1)) u_pt (.clk(clk), .en(en), .d(p_pk), .q(pq_pk));

  for (genvar i = 0; i < 3; i++) begin : g_dist
    always_ff @(posedge clk) begin
      if (en) begin
        dq[i] <= EW'(cpt[i]) - EW'($signed(pq_pk[i*W +: W]));
      end
    end
    stcp_mul #(.AW(EW), .BW(EW)) u_mul (
      .clk (clk), .en (en), .a (dq[i]), .b (dq[i]), .p (sqp[i])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dsum <= DDW'(sqp[0]) + DDW'(sqp[1]) + DDW'(sqp[2]);
    end
  end

  // ---------------- output register ----------------
  logic [CW+3*W-1:0]  o_pk_d, o_pk_q;
  logic [XW-1:0]      dx;
  logic [DIST_W-1:0]  dsat;
  ctl_t               ctl_o;
  logic signed [W-1:0] co [3];
  logic [DIST_W-1:0]  dist_o;
  logic               hit_o;

  assign o_pk_d = {ctl_c, c_pk};

  stcp_pipe #(.W(CW+3*W), .DEPTH(4)) u_outside (
    .clk (clk), .en (en), .d (o_pk_d), .q (o_pk_q)
  );

  assign dx   = XW'(unsigned'(dsum));
  assign dsat = (|dx[XW-1:DIST_W]) ? '1 : dx[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_o  <= ctl_t'(o_pk_q[CW+3*W-1:3*W]);
      dist_o <= dsat;
      hit_o  <= dsat <= DIST_W'(rr);
      for (int i = 0; i < 3; i++) begin
        co[i] <= $signed(o_pk_q[i*W +: W]);
      end
    end
  end

  assign result.closest_x   = co[0];
  assign result.closest_y   = co[1];
  assign result.closest_z   = co[2];
  assign result.region      = ctl_o.region;
  assign result.distance_sq = dist_o;
  assign result.hit         = hit_o;
  assign result.degenerate  = ctl_o.degen;

endmodule

// ===== rtl/core/stcp_mul.sv =====
// ----------------------------------------------------------------------------
// stcp_mul
// Signed multiplier split into 33x33 partial products; partials registered,
// then summed and registered.
// ----------------------------------------------------------------------------
module stcp_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [AW-1:0]   a,
  input  logic signed [BW-1:0]   b,
  output logic signed [AW+BW-1:0] p
);

  localparam int DG = 32;
  localparam int NA = (AW + DG - 1) / DG;
  localparam int NB = (BW + DG - 1) / DG;
  localparam int PW = AW + BW;
  localparam int SW = (NA + NB) * DG;

  logic signed [NA*DG-1:0] ax;
  logic signed [NB*DG-1:0] bx;
  logic signed [DG:0]      da [NA];
  logic signed [DG:0]      db [NB];
  logic signed [2*DG+1:0]  pp [NA][NB];
  logic signed [SW-1:0]    acc;

  assign ax = (NA*DG)'(a);
  assign bx = (NB*DG)'(b);

  // top digit keeps the sign, lower digits are unsigned
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      if (i == NA - 1) begin
        da[i] = {ax[i*DG+DG-1], ax[i*DG +: DG]};
      end else begin
        da[i] = {1'b0, ax[i*DG +: DG]};
      end
    end
    for (int j = 0; j < NB; j++) begin
      if (j == NB - 1) begin
        db[j] = {bx[j*DG+DG-1], bx[j*DG +: DG]};
      end else begin
        db[j] = {1'b0, bx[j*DG +: DG]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= da[i] * db[j];
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (SW'(pp[i][j]) << (DG * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= acc[PW-1:0];
    end
  end

endmodule

// ===== rtl/core/stcp_div.sv =====
// ----------------------------------------------------------------------------
// stcp_div
// Pipelined signed divider, round to nearest with ties away from zero.
// One quotient bit per stage; magnitude saturates at QW bits.
// ----------------------------------------------------------------------------
module stcp_div #(
  parameter int NW = 171,
  parameter int DW = 139,
  parameter int QW = 34
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [NW-1:0] num,
  input  logic signed [DW-1:0] den,
  output logic signed [QW:0]   quo
);

  localparam int RA = NW + 2;
  localparam int RB = DW + 1 + QW;
  localparam int RW = (RA > RB) ? RA : RB;

  logic [NW-1:0] an;
  logic [DW-1:0] ad;
  logic [RW-1:0] nn;
  logic [DW:0]   d2;

  logic [RW-1:0] rem [QW+1];
  logic [DW:0]   dv  [QW+1];
  logic [QW-1:0] qb  [QW+1];
  logic          ng  [QW+1];
  logic          ov  [QW+1];

  logic [QW-1:0] mag;

  assign an = num[NW-1] ? NW'(-num) : NW'(num);
  assign ad = den[DW-1] ? DW'(-den) : DW'(den);
  assign nn = (RW'(an) << 1) + RW'(ad);
  assign d2 = (DW+1)'(ad) << 1;

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= nn;
      dv[0]  <= d2;
      qb[0]  <= '0;
      ng[0]  <= num[NW-1] ^ den[DW-1];
      ov[0]  <= nn >= (RW'(d2) << QW);
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [RW-1:0] sh;
    logic          ge;

    assign sh = RW'(dv[k]) << (QW - 1 - k);
    assign ge = rem[k] >= sh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? rem[k] - sh : rem[k];
        qb[k+1]  <= qb[k] | (ge ? (QW'(1) << (QW - 1 - k)) : '0);
        dv[k+1]  <= dv[k];
        ng[k+1]  <= ng[k];
        ov[k+1]  <= ov[k];
      end
    end
  end

  assign mag = ov[QW] ? '1 : qb[QW];

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= ng[QW] ? -((QW+1)'(mag)) : (QW+1)'(mag);
    end
  end

endmodule

// ===== rtl/core/stcp_pipe.sv =====
// ----------------------------------------------------------------------------
// stcp_pipe
// Delay line with enable, keeps side data aligned with the datapath.
// ----------------------------------------------------------------------------
module stcp_pipe #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int k = 1; k < DEPTH; k++) begin
        sr[k] <= sr[k-1];
      end
    end
  end

  assign q = sr[DEPTH-1];

endmodule
